// ===== rtl/amff_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amff_pkg
// Shared constants, payload types and controller/datapath interface types
// for the first-free allocation map.
// ----------------------------------------------------------------------------
package amff_pkg;

  localparam int unsigned MapEntries = 256;
  localparam int unsigned EntryW     = 8;
  localparam int unsigned LimW       = 9;
  localparam int unsigned RowBits    = 32;
  localparam int unsigned BitW       = $clog2(RowBits);
  localparam int unsigned Rows       = MapEntries / RowBits;
  localparam int unsigned RowAw      = $clog2(Rows);
  // the entry field names at most 256 entries
  localparam int unsigned SearchMax  = (MapEntries < 256) ? MapEntries : 256;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_DEALLOC = 2'd1;
  localparam logic [1:0] KIND_FIND    = 2'd2;

  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_RANGE   = 3'd1;
  localparam logic [2:0] STS_USED    = 3'd2;
  localparam logic [2:0] STS_FREE    = 3'd3;
  localparam logic [2:0] STS_NOSPACE = 3'd4;

  localparam logic [LimW-1:0] LIM_RESET = LimW'(SearchMax);

  typedef struct packed {
    logic [1:0]        kind;
    logic [EntryW-1:0] entry;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [EntryW-1:0] result_entry;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_EVAL,
    S_RESP
  } state_e;

  typedef struct packed {
    logic load_req;
    logic rd_en;
    logic eval;
    logic step_row;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic more;
    logic out_free;
  } dp_sts_t;

  function automatic logic [LimW-1:0] eff_limit(input logic [LimW-1:0] v);
    logic [LimW-1:0] r;
    if (v > LimW'(SearchMax)) begin
      r = LimW'(SearchMax);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/amff_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amff_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module amff_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/amff_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amff_ctrl
// Request sequencer: accept, row read, evaluate (repeat for the free scan),
// hand the result to the output register.
// ----------------------------------------------------------------------------
module amff_ctrl
  import amff_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.more) begin
          cmd_o.step_row = 1'b1;
          state_d        = S_ISSUE;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/amff_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amff_dp
// Datapath: request and limit registers, row memory of used marks with
// per-row valid bits, row evaluation / priority encode, output register.
// ----------------------------------------------------------------------------
module amff_dp
  import amff_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  req_t            in_i,
  input  logic            cfg_we_i,
  input  logic [LimW-1:0] cfg_wdata_i,
  input  dp_cmd_t         cmd_i,
  output dp_sts_t         sts_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rsp_t            out_o
);

  req_t             req_q;
  logic [RowAw-1:0] row_q;
  logic [LimW-1:0]  lim_q;
  logic [Rows-1:0]  row_vld_q;
  logic             rd_vld_q;
  rsp_t             res_q, rsp_d;
  rsp_t             out_q;
  logic             out_valid_q;

  logic [RowAw-1:0]   rd_addr;
  logic [RowBits-1:0] ram_rdata, row_data, wr_data;
  logic               wr_ok;
  logic               is_find;
  logic [LimW-1:0]    base, next_base, rem;
  logic               base_below;
  logic [RowBits-1:0] cand;
  logic [BitW-1:0]    idx;
  logic               hit, last_row, in_rng, mark;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_i;
    end
    if (cmd_i.eval) begin
      res_q <= rsp_d;
    end
    if (cmd_i.push) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      lim_q       <= LIM_RESET;
      row_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_req) begin
        row_q <= '0;
      end else if (cmd_i.step_row) begin
        row_q <= row_q + RowAw'(1);
      end
      if (cfg_we_i) begin
        lim_q <= eff_limit(cfg_wdata_i);
      end
      if (cmd_i.rd_en) begin
        rd_vld_q <= row_vld_q[rd_addr];
      end
      if (cmd_i.eval && wr_ok) begin
        row_vld_q[rd_addr] <= 1'b1;
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign is_find = (req_q.kind == KIND_FIND);
  assign rd_addr = is_find ? row_q : req_q.entry[BitW +: RowAw];

  amff_ram #(
    .Width(RowBits),
    .Depth(Rows)
  ) u_marks (
    .clk_i  (clk_i),
    .we_i   (cmd_i.eval && wr_ok),
    .waddr_i(rd_addr),
    .wdata_i(wr_data),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // rows never written read as all free
  assign row_data = rd_vld_q ? ram_rdata : '0;

  // free scan over the current row, masked to entries below the limit
  assign base       = LimW'({row_q, {BitW{1'b0}}});
  assign next_base  = base + LimW'(RowBits);
  assign base_below = (base < lim_q);
  assign rem        = lim_q - base;

  always_comb begin
    for (int j = 0; j < RowBits; j++) begin
      cand[j] = !row_data[j] && base_below && (LimW'(j) < rem);
    end
  end

  always_comb begin
    idx = '0;
    for (int j = RowBits - 1; j >= 0; j--) begin
      if (cand[j]) begin
        idx = BitW'(j);
      end
    end
  end

  assign hit      = |cand;
  assign last_row = (row_q == RowAw'(Rows - 1)) || (next_base >= lim_q);

  assign in_rng = ({1'b0, req_q.entry} < lim_q);
  assign mark   = row_data[req_q.entry[BitW-1:0]];

  always_comb begin
    wr_data = row_data;
    wr_data[req_q.entry[BitW-1:0]] = (req_q.kind == KIND_ALLOC);
  end

  always_comb begin
    rsp_d = '{status: STS_RANGE, result_entry: '0};
    wr_ok = 1'b0;
    unique case (req_q.kind)
      KIND_ALLOC: begin
        if (in_rng && mark) begin
          rsp_d.status = STS_USED;
        end else if (in_rng) begin
          rsp_d = '{status: STS_OK, result_entry: req_q.entry};
          wr_ok = 1'b1;
        end
      end
      KIND_DEALLOC: begin
        if (in_rng && !mark) begin
          rsp_d.status = STS_FREE;
        end else if (in_rng) begin
          rsp_d = '{status: STS_OK, result_entry: req_q.entry};
          wr_ok = 1'b1;
        end
      end
      KIND_FIND: begin
        if (hit) begin
          rsp_d = '{status: STS_OK, result_entry: EntryW'({row_q, idx})};
        end else begin
          rsp_d.status = STS_NOSPACE;
        end
      end
      default: rsp_d.status = STS_RANGE;
    endcase
  end

  assign sts_o.more     = is_find && !hit && !last_row;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/allocation_map_first_free_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allocation_map_first_free_core
// Used/free bitmap allocator with allocate, deallocate and find-lowest-free.
// ----------------------------------------------------------------------------
// One request is worked on at a time. Allocate and deallocate run: accept,
// read of the 32-entry map row, check and write back, load of the output
// register (which waits while an untaken beat is still in it). Find-free reads
// one 32-entry row at a time through the single read port of the row memory,
// until a free entry is found, the limit is reached or the last of the 8
// rows of a 256-entry map is read. The map is free after reset with no
// clearing pass (per-row valid bits). A new request is taken while the
// previous result beat still waits. The limit write saturates at map size.
// ----------------------------------------------------------------------------
module allocation_map_first_free_core
  import amff_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  req_t            in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rsp_t            out_o,
  input  logic            cfg_we_i,
  input  logic [LimW-1:0] cfg_wdata_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  amff_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  amff_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  // one request in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // error results carry entry zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status != STS_OK) |-> (out_o.result_entry == '0))
    else $error("error result with nonzero entry");

  // no result beat is pushed while an accepted request is in its read and check steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !cmd.push ##1 !cmd.push)
    else $error("result pushed too early after accept");

endmodule
